FILE: rtl/sparse_sparse_dot_product_top_macros.svh
// Assertion macros used by the checker file.
// Each macro expects signals named clk and arst_n in the scope of its use.
`ifndef SPARSE_SPARSE_DOT_PRODUCT_TOP_MACROS_SVH
`define SPARSE_SPARSE_DOT_PRODUCT_TOP_MACROS_SVH

// Same-cycle implication.
`define SSDP_ASSERT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define SSDP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/ssdp_pkg.sv
package ssdp_pkg;

	localparam int POS_W       = 10;
	localparam int VAL_W       = 16;
	localparam int TAG_W       = 16;
	localparam int ACC_W       = 48;
	localparam int PROD_W      = 32;
	localparam int ENTRY_W     = POS_W + VAL_W;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;
	localparam int QCNT_W      = 3;

	localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

	typedef struct packed {
		logic                    operand_select;
		logic                    has_entry;
		logic [POS_W-1:0]        position;
		logic signed [VAL_W-1:0] value;
		logic                    last;
		logic [TAG_W-1:0]        result_tag;
	} in_item_t;

	typedef struct packed {
		logic signed [ACC_W-1:0] dot_product;
		logic [TAG_W-1:0]        tag_out;
		logic                    overflow;
	} out_item_t;

	typedef enum logic {
		OP_ROW,
		OP_COL
	} op_t;

	typedef struct packed {
		op_t                     op;
		logic                    has_entry;
		logic [POS_W-1:0]        position;
		logic signed [VAL_W-1:0] value;
		logic                    last;
		logic [TAG_W-1:0]        result_tag;
	} cmd_t;

endpackage

FILE: rtl/ssdp_stream_if.sv
interface ssdp_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/ssdp_ram.sv
module ssdp_ram #(
	parameter int WIDTH = 26,
	parameter int DEPTH = 64
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

FILE: rtl/ssdp_front.sv
module ssdp_front
	import ssdp_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	ssdp_stream_if.sink  in_ch,
	output cmd_t         head,
	output logic         head_valid,
	input  logic         pop
);
	cmd_t              queue_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              push;
	logic              do_pop;
	cmd_t              cmd;

	assign in_ch.ready = (count_q != QCNT_W'(QUEUE_DEPTH));
	assign push        = in_ch.valid && in_ch.ready;
	assign head_valid  = (count_q != '0);
	assign do_pop      = pop && head_valid;
	assign head        = queue_q[rd_ptr_q];

	always_comb begin
		cmd.op         = in_ch.data.operand_select ? OP_COL : OP_ROW;
		cmd.has_entry  = in_ch.data.has_entry;
		cmd.position   = in_ch.data.position;
		cmd.value      = in_ch.data.value;
		cmd.last       = in_ch.data.last;
		cmd.result_tag = in_ch.data.result_tag;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !do_pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (!push && do_pop) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end
endmodule

FILE: rtl/ssdp_back.sv
module ssdp_back
	import ssdp_pkg::*;
#(
	parameter int MAX_NONZEROS = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	input  cmd_t          head,
	input  logic          head_valid,
	output logic          pop,
	ssdp_stream_if.source out_ch
);
	localparam int PTR_W = (MAX_NONZEROS > 1) ? $clog2(MAX_NONZEROS) : 1;
	localparam int CNT_W = $clog2(MAX_NONZEROS + 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD,
		ST_CMP,
		ST_ACC,
		ST_EMIT
	} state_t;

	state_t                   state_q;
	cmd_t                     cur_q;
	logic [CNT_W-1:0]         row_count_q;
	logic                     row_closed_q;
	logic                     ovf_flag_q;
	logic [PTR_W-1:0]         ptr_q;
	logic                     exhausted_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic                     sat_q;
	logic signed [PROD_W-1:0] prod_s1;
	out_item_t                out_q;
	logic                     out_valid_q;

	logic [CNT_W-1:0]         eff_count;
	logic                     room;
	logic [PTR_W-1:0]         end_ptr;
	logic [PTR_W-1:0]         rd_addr;
	logic                     ram_we;
	logic [ENTRY_W-1:0]       rd_data;
	logic [POS_W-1:0]         rd_pos;
	logic signed [VAL_W-1:0]  rd_val;
	logic signed [PROD_W-1:0] mul_a;
	logic signed [PROD_W-1:0] mul_b;
	logic signed [ACC_W:0]    sum;
	logic signed [ACC_W-1:0]  sum_sat;
	logic                     sum_ovf;
	logic                     out_free;

	assign pop       = (state_q == ST_IDLE) && head_valid;
	assign eff_count = row_closed_q ? '0 : row_count_q;
	assign room      = (eff_count < CNT_W'(MAX_NONZEROS));
	assign end_ptr   = PTR_W'(row_count_q - CNT_W'(1));
	assign ram_we    = pop && (head.op == OP_ROW) && head.has_entry && room;
	assign rd_addr   = (state_q == ST_CMP) ? ptr_q + PTR_W'(1) : ptr_q;
	assign rd_pos    = rd_data[ENTRY_W-1:VAL_W];
	assign rd_val    = signed'(rd_data[VAL_W-1:0]);
	assign mul_a     = PROD_W'(rd_val);
	assign mul_b     = PROD_W'(cur_q.value);
	assign out_free  = !out_valid_q || out_ch.ready;

	always_comb begin
		sum     = {acc_q[ACC_W-1], acc_q} + {{(ACC_W + 1 - PROD_W){prod_s1[PROD_W-1]}}, prod_s1};
		sum_ovf = (sum[ACC_W] != sum[ACC_W-1]);
		if (sum_ovf) begin
			sum_sat = sum[ACC_W] ? ACC_MIN : ACC_MAX;
		end else begin
			sum_sat = sum[ACC_W-1:0];
		end
	end

	ssdp_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(MAX_NONZEROS)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(eff_count[PTR_W-1:0]),
		.wdata({head.position, head.value}),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	assign out_ch.valid = out_valid_q;
	assign out_ch.data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cur_q        <= '0;
			row_count_q  <= '0;
			row_closed_q <= 1'b0;
			ovf_flag_q   <= 1'b0;
			ptr_q        <= '0;
			exhausted_q  <= 1'b0;
			acc_q        <= '0;
			sat_q        <= 1'b0;
			prod_s1      <= '0;
			out_q        <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if ((state_q == ST_EMIT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (head_valid) begin
						cur_q <= head;
						if (head.op == OP_ROW) begin
							row_count_q  <= (head.has_entry && room) ?
								eff_count + CNT_W'(1) : eff_count;
							ovf_flag_q   <= (row_closed_q ? 1'b0 : ovf_flag_q) |
								(head.has_entry && !room);
							row_closed_q <= head.last;
						end else if (head.has_entry && (row_count_q != '0) &&
								!exhausted_q) begin
							if (ptr_q > end_ptr) begin
								ptr_q <= end_ptr;
							end
							state_q <= ST_RD;
						end else if (head.last) begin
							state_q <= ST_EMIT;
						end
					end
				end
				ST_RD: begin
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					if ((rd_pos < cur_q.position) && (ptr_q < end_ptr)) begin
						ptr_q <= ptr_q + PTR_W'(1);
					end else if (rd_pos == cur_q.position) begin
						prod_s1 <= mul_a * mul_b;
						if (ptr_q < end_ptr) begin
							ptr_q <= ptr_q + PTR_W'(1);
						end else begin
							exhausted_q <= 1'b1;
						end
						state_q <= ST_ACC;
					end else begin
						state_q <= cur_q.last ? ST_EMIT : ST_IDLE;
					end
				end
				ST_ACC: begin
					acc_q   <= sum_sat;
					sat_q   <= sat_q | sum_ovf;
					state_q <= cur_q.last ? ST_EMIT : ST_IDLE;
				end
				ST_EMIT: begin
					if (out_free) begin
						out_q.dot_product <= acc_q;
						out_q.tag_out     <= cur_q.result_tag;
						out_q.overflow    <= ovf_flag_q | sat_q;
						acc_q             <= '0;
						ptr_q             <= '0;
						exhausted_q       <= 1'b0;
						sat_q             <= 1'b0;
						state_q           <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end
endmodule

FILE: rtl/sparse_sparse_dot_product_top.sv
// A row item is handled by the back end in the cycle it leaves the four-entry input queue.
// A column entry that cannot match is handled in the idle state; otherwise it passes through
// the read and compare states, where the walk pointer visits the stored entries (one RAM read
// a cycle), and on a match the accumulate state. A closing column item waits in the emit state
// while the previous result is still held; its result is valid in the cycle after it leaves.
// Reset is asynchronous and clears all control state; the nonzero store is not cleared.
module sparse_sparse_dot_product_top
	import ssdp_pkg::*;
#(
	parameter int MAX_NONZEROS = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	ssdp_stream_if.sink   in_ch,
	ssdp_stream_if.source out_ch
);
	cmd_t head;
	logic head_valid;
	logic pop;

	ssdp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.head      (head),
		.head_valid(head_valid),
		.pop       (pop)
	);

	ssdp_back #(
		.MAX_NONZEROS(MAX_NONZEROS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.head_valid(head_valid),
		.pop       (pop),
		.out_ch    (out_ch)
	);
endmodule

FILE: rtl/ssdp_checker.sv
`include "sparse_sparse_dot_product_top_macros.svh"

module ssdp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        in_operand_select,
	input logic        in_last,
	input logic        out_valid,
	input logic        out_ready,
	input logic [47:0] out_dot_product,
	input logic [15:0] out_tag,
	input logic        out_overflow
);
	logic [2:0] pending_q;
	logic       close_in;
	logic       result_out;

	assign close_in   = in_valid && in_ready && in_operand_select && in_last;
	assign result_out = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (close_in && !result_out) begin
			pending_q <= pending_q + 3'd1;
		end else if (!close_in && result_out) begin
			pending_q <= pending_q - 3'd1;
		end
	end

	`SSDP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_dot_product) && $stable(out_tag) && $stable(out_overflow), "result item changed while stalled")
	`SSDP_ASSERT(a_no_orphan, out_valid, pending_q != 3'd0, "result item without a closing column item")
	`SSDP_ASSERT(a_bounded, close_in, pending_q < 3'd6, "more closing items in flight than the block can hold")
endmodule

bind sparse_sparse_dot_product_top ssdp_checker u_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.in_valid         (in_ch.valid),
	.in_ready         (in_ch.ready),
	.in_operand_select(in_ch.data.operand_select),
	.in_last          (in_ch.data.last),
	.out_valid        (out_ch.valid),
	.out_ready        (out_ch.ready),
	.out_dot_product  (out_ch.data.dot_product),
	.out_tag          (out_ch.data.tag_out),
	.out_overflow     (out_ch.data.overflow)
);
